// ===== rtl/rfk_pkg.sv =====
// shared types and constants for the fsk character keyer
`default_nettype none

package rfk_pkg;

    // item classes decoded from the input kind field
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_SEND  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_START = 3'd2,
        PH_DATA  = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KEY_SPACE = 2'd0,
        KEY_MARK  = 2'd1,
        KEY_NONE  = 2'd3
    } key_t;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int HALF_W     = 16;
    localparam int TICKS_W    = 24;
    localparam int COUNT_W    = 8;
    localparam int KIND_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MARK_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_STOPS  = 3'd4;

    localparam logic [HALF_W-1:0]  MARK_HALF_RST  = 16'd235;
    localparam logic [HALF_W-1:0]  SPACE_HALF_RST = 16'd218;
    localparam logic [TICKS_W-1:0] BIT_TICKS_RST  = 24'd22000;
    localparam logic [TICKS_W-1:0] STOP_TICKS_RST = 24'd33000;
    localparam logic [COUNT_W-1:0] PRE_STOPS_RST  = 8'd40;

endpackage

`default_nettype wire

// ===== rtl/rfk_if.sv =====
// valid/ready channel interfaces for command input and status output
`default_nettype none

interface rfk_in_if #(parameter int CODE_BITS = 5);
    import rfk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CODE_BITS-1:0] code;

    modport source (output valid, output kind, output code, input ready);
    modport sink   (input valid, input kind, input code, output ready);
endinterface

interface rfk_out_if;
    logic valid;
    logic ready;
    logic tone_out;
    logic keyed_mark;
    logic ptt_on;
    logic busy_res;
    logic rejected;

    modport source (output valid, output tone_out, output keyed_mark, output ptt_on,
                    output busy_res, output rejected, input ready);
    modport sink   (input valid, input tone_out, input keyed_mark, input ptt_on,
                    input busy_res, input rejected, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtty_fsk_character_keyer.sv =====
// top level: fsk teleprinter keyer, command queue feeding the frame sequencer
// path: each item is held in a queue entry, then its result in the result register
// throughput: one item per cycle while the result output is not stalled
// the 2-entry queue lets input transfers continue while a result waits on the output, until it is full
// reset: asynchronous active low; idle, internal tone and push-to-talk state off, settings at defaults
`default_nettype none

module rtty_fsk_character_keyer
    import rfk_pkg::*;
#(
    parameter int CODE_BITS = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rfk_in_if.sink                     in_ch,
    rfk_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    q_head_t              head;
    logic [CODE_BITS-1:0] head_code;
    logic                 pop;

    rfk_front #(.CODE_BITS(CODE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.kind),
        .in_code   (in_ch.code),
        .head      (head),
        .head_code (head_code),
        .pop       (pop)
    );

    rfk_back #(.CODE_BITS(CODE_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .head_code  (head_code),
        .pop        (pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .tone_out   (out_ch.tone_out),
        .keyed_mark (out_ch.keyed_mark),
        .ptt_on     (out_ch.ptt_on),
        .busy_res   (out_ch.busy_res),
        .rejected   (out_ch.rejected)
    );

endmodule

`default_nettype wire

// ===== rtl/rfk_front.sv =====
// front end: accepts items, decodes their class and queues them
`default_nettype none

module rfk_front
    import rfk_pkg::*;
#(
    parameter int CODE_BITS = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [KIND_W-1:0]    in_kind,
    input  wire logic [CODE_BITS-1:0] in_code,
    output q_head_t                   head,
    output logic [CODE_BITS-1:0]      head_code,
    input  wire logic                 pop
);

    op_t                  op_dec;
    op_t                  op_mem [2];
    logic [CODE_BITS-1:0] code_mem [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push;

    always_comb
    begin
        unique case (op_t'(in_kind))
            OP_TICK:  op_dec = OP_TICK;
            OP_BEGIN: op_dec = OP_BEGIN;
            OP_SEND:  op_dec = OP_SEND;
            default:  op_dec = OP_END;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= op_dec;
            code_mem[wr_ptr_reg] <= in_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = '{valid: (count_reg != 2'd0), op: op_mem[rd_ptr_reg]};
    assign head_code = code_mem[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/rfk_back.sv =====
// back end: frame sequencer, tone generator, settings and result register
`default_nettype none

module rfk_back
    import rfk_pkg::*;
#(
    parameter int CODE_BITS = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire q_head_t               head,
    input  wire logic [CODE_BITS-1:0]  head_code,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       tone_out,
    output logic                       keyed_mark,
    output logic                       ptt_on,
    output logic                       busy_res,
    output logic                       rejected
);

    localparam int BIT_W = $clog2(CODE_BITS);
    localparam logic [BIT_W-1:0] MSB_IDX = BIT_W'(CODE_BITS - 1);

    logic [HALF_W-1:0]  mark_half_reg, space_half_reg;
    logic [TICKS_W-1:0] bit_ticks_reg, stop_ticks_reg;
    logic [COUNT_W-1:0] pre_stops_reg;

    phase_t               phase_reg, phase_next;
    logic [BIT_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [TICKS_W-1:0]   elem_reg, elem_next;
    logic [COUNT_W-1:0]   repeat_reg, repeat_next, repeat_dec;
    logic [CODE_BITS-1:0] shift_reg, shift_next;
    logic [HALF_W-1:0]    tone_timer_reg, tone_timer_next;
    logic                 tone_level_reg, tone_level_next;
    key_t                 key_reg, key_next;
    logic                 ptt_reg, ptt_next;

    logic                 want_set;
    key_t                 want_key;
    logic [BIT_W-1:0]     next_idx;
    logic                 rej;

    logic out_valid_reg, out_valid_next;
    logic tone_out_reg, keyed_mark_reg, ptt_on_reg, busy_res_reg, rejected_reg;

    assign pop        = head.valid && (!out_valid_reg || out_ready);
    assign repeat_dec = repeat_reg - COUNT_W'(1);
    assign next_idx   = bit_idx_reg + BIT_W'(1);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        bit_idx_next    = bit_idx_reg;
        elem_next       = elem_reg;
        repeat_next     = repeat_reg;
        shift_next      = shift_reg;
        tone_timer_next = tone_timer_reg;
        tone_level_next = tone_level_reg;
        key_next        = key_reg;
        ptt_next        = ptt_reg;
        want_set        = 1'b0;
        want_key        = key_reg;
        rej             = 1'b0;

        if (pop)
        begin
            if (head.op != OP_TICK && phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                unique case (head.op)
                    OP_TICK:
                    begin
                        // tone advances first with the current key
                        if (key_reg == KEY_NONE)
                        begin
                            tone_level_next = 1'b0;
                        end
                        else if (tone_timer_reg <= HALF_W'(1))
                        begin
                            tone_level_next = ~tone_level_reg;
                            tone_timer_next = (key_reg == KEY_MARK) ? mark_half_reg
                                                                    : space_half_reg;
                        end
                        else
                        begin
                            tone_timer_next = tone_timer_reg - HALF_W'(1);
                        end

                        if (phase_reg != PH_IDLE)
                        begin
                            if (elem_reg > TICKS_W'(1))
                            begin
                                elem_next = elem_reg - TICKS_W'(1);
                            end
                            else
                            begin
                                elem_next = '0;
                                unique case (phase_reg)
                                    PH_PRE:
                                    begin
                                        repeat_next = repeat_dec;
                                        if (repeat_dec != '0)
                                            elem_next = stop_ticks_reg;
                                        else
                                            phase_next = PH_IDLE;
                                    end
                                    PH_START:
                                    begin
                                        phase_next   = PH_DATA;
                                        bit_idx_next = '0;
                                        want_set     = 1'b1;
                                        want_key     = shift_reg[MSB_IDX] ? KEY_MARK
                                                                          : KEY_SPACE;
                                        elem_next    = bit_ticks_reg;
                                    end
                                    PH_DATA:
                                    begin
                                        want_set = 1'b1;
                                        if (bit_idx_reg != MSB_IDX)
                                        begin
                                            bit_idx_next = next_idx;
                                            want_key     = shift_reg[MSB_IDX - next_idx]
                                                           ? KEY_MARK : KEY_SPACE;
                                            elem_next    = bit_ticks_reg;
                                        end
                                        else
                                        begin
                                            phase_next = PH_STOP;
                                            want_key   = KEY_MARK;
                                            elem_next  = stop_ticks_reg;
                                        end
                                    end
                                    default:
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                endcase
                            end
                        end
                    end
                    OP_BEGIN:
                    begin
                        ptt_next    = 1'b1;
                        want_set    = 1'b1;
                        want_key    = KEY_MARK;
                        repeat_next = pre_stops_reg;
                        if (pre_stops_reg != '0)
                        begin
                            phase_next = PH_PRE;
                            elem_next  = stop_ticks_reg;
                        end
                    end
                    OP_SEND:
                    begin
                        shift_next   = head_code;
                        phase_next   = PH_START;
                        bit_idx_next = '0;
                        want_set     = 1'b1;
                        want_key     = KEY_SPACE;
                        elem_next    = bit_ticks_reg;
                    end
                    default:
                    begin
                        key_next        = KEY_NONE;
                        tone_level_next = 1'b0;
                        tone_timer_next = '0;
                        ptt_next        = 1'b0;
                    end
                endcase

                // phase restarts only on a change of keyed level
                if (want_set && want_key != key_reg)
                begin
                    key_next        = want_key;
                    tone_level_next = 1'b1;
                    tone_timer_next = (want_key == KEY_MARK) ? mark_half_reg : space_half_reg;
                end
            end
        end
    end

    // result of the item
    always_comb
    begin
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tone_out_reg   <= (key_next != KEY_NONE) && tone_level_next;
            keyed_mark_reg <= (key_next == KEY_MARK);
            ptt_on_reg     <= ptt_next;
            busy_res_reg   <= (phase_next != PH_IDLE);
            rejected_reg   <= rej;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_idx_reg    <= '0;
            elem_reg       <= '0;
            repeat_reg     <= '0;
            shift_reg      <= '0;
            tone_timer_reg <= '0;
            tone_level_reg <= 1'b0;
            key_reg        <= KEY_NONE;
            ptt_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_idx_reg    <= bit_idx_next;
            elem_reg       <= elem_next;
            repeat_reg     <= repeat_next;
            shift_reg      <= shift_next;
            tone_timer_reg <= tone_timer_next;
            tone_level_reg <= tone_level_next;
            key_reg        <= key_next;
            ptt_reg        <= ptt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_half_reg  <= MARK_HALF_RST;
            space_half_reg <= SPACE_HALF_RST;
            bit_ticks_reg  <= BIT_TICKS_RST;
            stop_ticks_reg <= STOP_TICKS_RST;
            pre_stops_reg  <= PRE_STOPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MARK_HALF:  mark_half_reg  <= cfg_data[HALF_W-1:0];
                CFG_SPACE_HALF: space_half_reg <= cfg_data[HALF_W-1:0];
                CFG_BIT_TICKS:  bit_ticks_reg  <= cfg_data[TICKS_W-1:0];
                CFG_STOP_TICKS: stop_ticks_reg <= cfg_data[TICKS_W-1:0];
                CFG_PRE_STOPS:  pre_stops_reg  <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign tone_out   = tone_out_reg;
    assign keyed_mark = keyed_mark_reg;
    assign ptt_on     = ptt_on_reg;
    assign busy_res   = busy_res_reg;
    assign rejected   = rejected_reg;

endmodule

`default_nettype wire

// ===== rtl/rfk_checker.sv =====
// port-level assertions for the keyer and their bind to the top level
`default_nettype none

module rfk_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic tone_out,
    input wire logic keyed_mark,
    input wire logic ptt_on,
    input wire logic busy_res,
    input wire logic rejected
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({tone_out, keyed_mark, ptt_on, busy_res, rejected}))
        else $error("result changed while stalled");

    // a dropped command leaves the frame running
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> busy_res)
        else $error("reject reported while not busy");

    // no result comes out of reset before an item
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind rtty_fsk_character_keyer rfk_checker u_rfk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .tone_out   (out_ch.tone_out),
    .keyed_mark (out_ch.keyed_mark),
    .ptt_on     (out_ch.ptt_on),
    .busy_res   (out_ch.busy_res),
    .rejected   (out_ch.rejected)
);

`default_nettype wire
